>>> rtl/core/wsjq_pkg.sv
// Package for the work-stealing job queues: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package wsjq_pkg;

   localparam int MAX_WORKER_QUEUES = 32;
   localparam int QUEUE_DEPTH       = 64;
   localparam int JOB_ID_BITS       = 16;
   localparam int NUM_QUEUES        = MAX_WORKER_QUEUES + 1;
   localparam int Q_BITS            = $clog2(NUM_QUEUES);
   localparam int POS_BITS          = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS         = $clog2(QUEUE_DEPTH + 1);
   localparam int META_BITS         = POS_BITS + FILL_BITS;
   localparam int STORE_DEPTH       = NUM_QUEUES * QUEUE_DEPTH;
   localparam int STORE_AW          = $clog2(STORE_DEPTH);

   localparam int THREAD_BITS       = 6;
   localparam int WC_BITS           = 6;
   localparam int VICTIM_BITS       = 5;
   localparam int STATUS_BITS       = 2;
   localparam int SOURCE_BITS       = 2;

   localparam int STEAL_PRIME       = 7919;
   localparam int DIVIDEND_BITS     = 18;
   localparam int DIV_CNT_BITS      = $clog2(DIVIDEND_BITS + 1);
   localparam logic [WC_BITS-1:0] WC_RESET = WC_BITS'(4);
   localparam logic [WC_BITS-1:0] WC_MAX   = WC_BITS'(MAX_WORKER_QUEUES);

   localparam logic REQ_SUBMIT = 1'b0;
   localparam logic REQ_FETCH  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_BAD_THRD = 2'd3;

   localparam logic [SOURCE_BITS-1:0] SRC_OWN    = 2'd0;
   localparam logic [SOURCE_BITS-1:0] SRC_SHARED = 2'd1;
   localparam logic [SOURCE_BITS-1:0] SRC_STOLEN = 2'd2;

   typedef enum logic [1:0] {
      SEL_OWN    = 2'd0,
      SEL_SHARED = 2'd1,
      SEL_VICTIM = 2'd2
   } sel_type;

   typedef enum logic [1:0] {
      OP_NONE      = 2'd0,
      OP_PUSH      = 2'd1,
      OP_POP_BACK  = 2'd2,
      OP_POP_FRONT = 2'd3
   } op_type;

   typedef struct packed {
      logic                   capture;
      logic                   meta_rd;
      sel_type                sel;
      op_type                 op;
      logic                   div_start;
      logic                   vic_init;
      logic                   vic_next;
      logic                   set_res;
      logic [STATUS_BITS-1:0] res_status;
      logic [SOURCE_BITS-1:0] res_source;
      logic                   latch_job;
      logic                   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic bad_thread;
      logic is_fetch;
      logic t_zero;
      logic full;
      logic empty;
      logic wc_gt1;
      logic div_busy;
      logic vic_skip;
      logic vic_last;
      logic rsp_busy;
   } stat_type;

endpackage

>>> rtl/core/wsjq_if.sv
// Valid/ready channel interfaces for requests, responses and the CSR write.
// Depends on wsjq_pkg.
interface wsjq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [wsjq_pkg::THREAD_BITS-1:0]      thread_index;
   logic [wsjq_pkg::JOB_ID_BITS-1:0]      job_id;
   modport source (output valid, req_type, thread_index, job_id, input ready);
   modport sink   (input valid, req_type, thread_index, job_id, output ready);
endinterface

interface wsjq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [wsjq_pkg::STATUS_BITS-1:0]      status;
   logic [wsjq_pkg::JOB_ID_BITS-1:0]      job_out;
   logic [wsjq_pkg::SOURCE_BITS-1:0]      job_source;
   logic [wsjq_pkg::VICTIM_BITS-1:0]      victim_worker;
   modport source (output valid, status, job_out, job_source, victim_worker,
                   input ready);
   modport sink   (input valid, status, job_out, job_source, victim_worker,
                   output ready);
endinterface

interface wsjq_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [wsjq_pkg::WC_BITS-1:0]          data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/wsjq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsjq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/wsjq_dpath.sv
// Datapath: request capture, queue head/fill and job stores, start-index
// remainder unit, victim walk and response register. Uses wsjq_pkg, wsjq_ram.
module wsjq_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wsjq_pkg::cmd_type                    cmd,
   output wsjq_pkg::stat_type                   stat,
   input  logic                                 req_type,
   input  logic [wsjq_pkg::THREAD_BITS-1:0]     thread_index,
   input  logic [wsjq_pkg::JOB_ID_BITS-1:0]     job_id,
   input  logic                                 csr_valid,
   input  logic [wsjq_pkg::WC_BITS-1:0]         csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wsjq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [wsjq_pkg::JOB_ID_BITS-1:0]     rsp_job_out,
   output logic [wsjq_pkg::SOURCE_BITS-1:0]     rsp_job_source,
   output logic [wsjq_pkg::VICTIM_BITS-1:0]     rsp_victim_worker
);
   import wsjq_pkg::*;

   logic [WC_BITS-1:0]      worker_count_ff, worker_count_in;
   logic                    type_ff;
   logic [THREAD_BITS-1:0]  t_ff;
   logic [JOB_ID_BITS-1:0]  job_ff;
   logic [WC_BITS-1:0]      wc_ff;
   logic [Q_BITS-1:0]       q_ff, q_in;
   logic [NUM_QUEUES-1:0]   valid_ff, valid_in;
   logic                    meta_vld_ff;

   logic [DIV_CNT_BITS-1:0]  div_cnt_ff, div_cnt_in;
   logic [DIVIDEND_BITS-1:0] div_num_ff, div_num_in;
   logic [WC_BITS-1:0]       div_rem_ff, div_rem_in;
   logic [WC_BITS:0]         div_try;

   logic [VICTIM_BITS-1:0]  v_ff, v_in;
   logic [VICTIM_BITS-1:0]  i_ff, i_in;
   logic [WC_BITS-1:0]      v_plus1;

   logic [STATUS_BITS-1:0]  res_status_ff;
   logic [SOURCE_BITS-1:0]  res_source_ff;
   logic [JOB_ID_BITS-1:0]  res_job_ff;
   logic [VICTIM_BITS-1:0]  res_victim_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff;
   logic [JOB_ID_BITS-1:0]  rsp_job_ff;
   logic [SOURCE_BITS-1:0]  rsp_source_ff;
   logic [VICTIM_BITS-1:0]  rsp_victim_ff;

   logic [WC_BITS-1:0]      wc_eff;
   logic [META_BITS-1:0]    meta_raw, meta_wdata;
   logic [POS_BITS-1:0]     head, new_head, pos;
   logic [FILL_BITS-1:0]    fill, new_fill;
   logic [FILL_BITS:0]      pos_sum;
   logic [Q_BITS-1:0]       rd_q;
   logic                    meta_we, store_we, store_re;
   logic [STORE_AW-1:0]     store_addr;
   logic [JOB_ID_BITS-1:0]  store_rdata;

   assign wc_eff = (worker_count_ff > WC_MAX) ? WC_MAX : worker_count_ff;

   // Queue metadata: head and fill per queue, valid bits give the reset value.
   wsjq_ram #(.WIDTH(META_BITS), .DEPTH(NUM_QUEUES)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (q_ff),
      .wr_data (meta_wdata),
      .rd_en   (cmd.meta_rd),
      .rd_addr (rd_q),
      .rd_data (meta_raw)
   );

   wsjq_ram #(.WIDTH(JOB_ID_BITS), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_addr),
      .wr_data (job_ff),
      .rd_en   (store_re),
      .rd_addr (store_addr),
      .rd_data (store_rdata)
   );

   assign head = meta_vld_ff ? meta_raw[META_BITS-1:FILL_BITS] : '0;
   assign fill = meta_vld_ff ? meta_raw[FILL_BITS-1:0] : '0;

   assign v_plus1 = WC_BITS'(v_ff) + WC_BITS'(1);

   always_comb begin
      unique case (cmd.sel)
         SEL_OWN:    rd_q = Q_BITS'(t_ff);
         SEL_SHARED: rd_q = '0;
         SEL_VICTIM: rd_q = Q_BITS'(v_plus1);
         default:    rd_q = '0;
      endcase
   end

   // Ring position and new head/fill for the selected queue operation.
   always_comb begin
      pos_sum  = '0;
      new_head = head;
      new_fill = fill;
      meta_we  = 1'b0;
      store_we = 1'b0;
      store_re = 1'b0;
      unique case (cmd.op)
         OP_PUSH: begin
            pos_sum  = (FILL_BITS+1)'(head) + (FILL_BITS+1)'(fill);
            new_fill = fill + FILL_BITS'(1);
            meta_we  = 1'b1;
            store_we = 1'b1;
         end
         OP_POP_BACK: begin
            pos_sum  = (FILL_BITS+1)'(head) + (FILL_BITS+1)'(fill)
                       - (FILL_BITS+1)'(1);
            new_fill = fill - FILL_BITS'(1);
            meta_we  = 1'b1;
            store_re = 1'b1;
         end
         OP_POP_FRONT: begin
            pos_sum  = (FILL_BITS+1)'(head);
            new_head = (head == POS_BITS'(QUEUE_DEPTH - 1)) ? '0 : head + POS_BITS'(1);
            new_fill = fill - FILL_BITS'(1);
            meta_we  = 1'b1;
            store_re = 1'b1;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
      if (pos_sum >= (FILL_BITS+1)'(QUEUE_DEPTH)) begin
         pos = POS_BITS'(pos_sum - (FILL_BITS+1)'(QUEUE_DEPTH));
      end else begin
         pos = POS_BITS'(pos_sum);
      end
   end

   assign meta_wdata = {new_head, new_fill};
   assign store_addr = STORE_AW'(q_ff) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(pos);

   always_comb begin
      valid_in = valid_ff;
      if (meta_we) begin
         valid_in[q_ff] = 1'b1;
      end
   end

   assign q_in = cmd.meta_rd ? rd_q : q_ff;

   // Start index: serial restoring remainder of (t+1)*prime by the count.
   always_comb begin
      div_cnt_in = div_cnt_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_try    = {div_rem_ff, div_num_ff[DIVIDEND_BITS-1]};
      if (cmd.div_start) begin
         div_cnt_in = DIV_CNT_BITS'(DIVIDEND_BITS);
         div_num_in = DIVIDEND_BITS'((DIVIDEND_BITS'(t_ff) + DIVIDEND_BITS'(1))
                      * DIVIDEND_BITS'(STEAL_PRIME));
         div_rem_in = '0;
      end else if (div_cnt_ff != '0) begin
         if (div_try >= (WC_BITS+1)'(wc_ff)) begin
            div_try = div_try - (WC_BITS+1)'(wc_ff);
         end
         div_rem_in = WC_BITS'(div_try);
         div_num_in = div_num_ff << 1;
         div_cnt_in = div_cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   always_comb begin
      v_in = v_ff;
      i_in = i_ff;
      if (cmd.vic_init) begin
         v_in = VICTIM_BITS'(div_rem_ff);
         i_in = '0;
      end else if (cmd.vic_next) begin
         v_in = (v_plus1 == wc_ff) ? '0 : VICTIM_BITS'(v_plus1);
         i_in = i_ff + VICTIM_BITS'(1);
      end
   end

   assign worker_count_in = csr_valid ? csr_data : worker_count_ff;
   assign rsp_valid_in    = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WC_RESET;
         valid_ff        <= '0;
         meta_vld_ff     <= 1'b0;
         div_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         worker_count_ff <= worker_count_in;
         valid_ff        <= valid_in;
         if (cmd.meta_rd) begin
            meta_vld_ff <= valid_ff[rd_q];
         end
         div_cnt_ff      <= div_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         t_ff    <= thread_index;
         job_ff  <= job_id;
         wc_ff   <= wc_eff;
      end
      q_ff       <= q_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      v_ff       <= v_in;
      i_ff       <= i_in;
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_source_ff <= cmd.res_source;
         res_job_ff    <= '0;
         res_victim_ff <= (cmd.res_source == SRC_STOLEN) ? v_ff : '0;
      end
      if (cmd.latch_job) begin
         res_job_ff <= store_rdata;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_job_ff    <= res_job_ff;
         rsp_source_ff <= res_source_ff;
         rsp_victim_ff <= res_victim_ff;
      end
   end

   assign stat.bad_thread = t_ff > wc_ff;
   assign stat.is_fetch   = type_ff == REQ_FETCH;
   assign stat.t_zero     = t_ff == '0;
   assign stat.full       = fill >= FILL_BITS'(QUEUE_DEPTH);
   assign stat.empty      = fill == '0;
   assign stat.wc_gt1     = wc_ff > WC_BITS'(1);
   assign stat.div_busy   = div_cnt_ff != '0;
   assign stat.vic_skip   = v_plus1 == t_ff;
   assign stat.vic_last   = WC_BITS'(i_ff) == wc_ff - WC_BITS'(1);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_job_out       = rsp_job_ff;
   assign rsp_job_source    = rsp_source_ff;
   assign rsp_victim_worker = rsp_victim_ff;
endmodule

>>> rtl/core/wsjq_ctrl.sv
// Controller: sequences submit, own pop, shared pop and the steal walk.
// Depends on wsjq_pkg.
module wsjq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wsjq_pkg::stat_type stat,
   output wsjq_pkg::cmd_type  cmd
);
   import wsjq_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_PUSH  = 10'b0000000100,
      S_OWN   = 10'b0000001000,
      S_SHR   = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_VCHK  = 10'b0001000000,
      S_VRD   = 10'b0010000000,
      S_DATA  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = SEL_OWN;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.bad_thread) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BAD_THRD;
               state_in       = S_DONE;
            end else if (!stat.is_fetch) begin
               cmd.meta_rd = 1'b1;
               state_in    = S_PUSH;
            end else begin
               cmd.div_start = 1'b1;
               cmd.meta_rd   = 1'b1;
               if (stat.t_zero) begin
                  cmd.sel  = SEL_SHARED;
                  state_in = S_SHR;
               end else begin
                  state_in = S_OWN;
               end
            end
         end
         S_PUSH: begin
            cmd.set_res = 1'b1;
            if (stat.full) begin
               cmd.res_status = ST_FULL;
            end else begin
               cmd.op = OP_PUSH;
            end
            state_in = S_DONE;
         end
         S_OWN: begin
            if (!stat.empty) begin
               cmd.op      = OP_POP_BACK;
               cmd.set_res = 1'b1;
               state_in    = S_DATA;
            end else begin
               cmd.meta_rd = 1'b1;
               cmd.sel     = SEL_SHARED;
               state_in    = S_SHR;
            end
         end
         S_SHR: begin
            cmd.set_res = 1'b1;
            if (!stat.empty) begin
               cmd.op         = OP_POP_FRONT;
               cmd.res_source = SRC_SHARED;
               state_in       = S_DATA;
            end else if (stat.wc_gt1) begin
               state_in = S_DIV;
            end else begin
               cmd.res_status = ST_EMPTY;
               state_in       = S_DONE;
            end
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               cmd.vic_init = 1'b1;
               state_in     = S_VCHK;
            end
         end
         S_VCHK: begin
            if (stat.vic_skip) begin
               if (stat.vic_last) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_EMPTY;
                  state_in       = S_DONE;
               end else begin
                  cmd.vic_next = 1'b1;
               end
            end else begin
               cmd.meta_rd = 1'b1;
               cmd.sel     = SEL_VICTIM;
               state_in    = S_VRD;
            end
         end
         S_VRD: begin
            if (!stat.empty) begin
               cmd.op         = OP_POP_FRONT;
               cmd.set_res    = 1'b1;
               cmd.res_source = SRC_STOLEN;
               state_in       = S_DATA;
            end else if (stat.vic_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_EMPTY;
               state_in       = S_DONE;
            end else begin
               cmd.vic_next = 1'b1;
               state_in     = S_VCHK;
            end
         end
         S_DATA: begin
            cmd.latch_job = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the response slot frees up
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> rtl/core/work_stealing_job_queues.sv
// Top level of the work-stealing job queues: controller plus datapath.
// Depends on wsjq_pkg, wsjq_if, wsjq_ctrl, wsjq_dpath.
//
// One request is handled at a time and each request returns one response.
// A fetch that steals runs a serial remainder to find the start deque, then
// visits victims in turn, each by a metadata read and then a check. The next
// request is accepted in the cycle after a response is loaded, even if that
// response is still waiting to be taken. Queue metadata sits in a 33-entry
// RAM with reset-cleared valid bits, so no clearing pass runs after reset;
// job slots sit in one shared RAM that is read only where filled.
module work_stealing_job_queues (
   input  logic           clock,
   input  logic           reset,
   wsjq_req_if.sink       req_bus,
   wsjq_rsp_if.source     rsp_bus,
   wsjq_csr_if.sink       csr_bus
);
   import wsjq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   wsjq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wsjq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_bus.req_type),
      .thread_index      (req_bus.thread_index),
      .job_id            (req_bus.job_id),
      .csr_valid         (csr_bus.valid),
      .csr_data          (csr_bus.data),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_job_out       (rsp_bus.job_out),
      .rsp_job_source    (rsp_bus.job_source),
      .rsp_victim_worker (rsp_bus.victim_worker)
   );
endmodule
